// ----- rtl/mlk_pkg.sv -----
// Package for the Morse letter keyer: field widths, codes and the letter table.
// No dependencies; every other file of the block imports it.
`default_nettype none

package mlk_pkg;

	localparam int UnitW   = 24;
	localparam int LetterW = 5;
	localparam int StatusW = 2;
	localparam int PatW    = 4;
	localparam int CountW  = 3;
	localparam int IndexW  = 2;
	localparam int UnitsW  = 2;

	localparam logic [UnitW-1:0]   UNIT_TICKS_RST = 24'd300000;
	localparam logic [LetterW-1:0] LETTER_COUNT   = 5'd26;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_TICK = 1'b1
	} req_type_t;

	typedef enum logic [StatusW-1:0] {
		ST_TICK    = 2'd0,
		ST_LOADED  = 2'd1,
		ST_BUSY    = 2'd2,
		ST_INVALID = 2'd3
	} load_status_t;

	typedef struct packed {
		logic [PatW-1:0]   pattern;
		logic [CountW-1:0] count;
	} morse_code_t;

	// Bit i of the pattern is mark i, a one being a dash.
	function automatic morse_code_t morse_lookup(input logic [LetterW-1:0] letter);
		morse_code_t c;
		case (letter)
			5'd0:    c = '{4'd2,  3'd2};
			5'd1:    c = '{4'd1,  3'd4};
			5'd2:    c = '{4'd5,  3'd4};
			5'd3:    c = '{4'd1,  3'd3};
			5'd4:    c = '{4'd0,  3'd1};
			5'd5:    c = '{4'd4,  3'd4};
			5'd6:    c = '{4'd3,  3'd3};
			5'd7:    c = '{4'd0,  3'd4};
			5'd8:    c = '{4'd0,  3'd2};
			5'd9:    c = '{4'd14, 3'd4};
			5'd10:   c = '{4'd5,  3'd3};
			5'd11:   c = '{4'd2,  3'd4};
			5'd12:   c = '{4'd3,  3'd2};
			5'd13:   c = '{4'd1,  3'd2};
			5'd14:   c = '{4'd7,  3'd3};
			5'd15:   c = '{4'd6,  3'd4};
			5'd16:   c = '{4'd11, 3'd4};
			5'd17:   c = '{4'd2,  3'd3};
			5'd18:   c = '{4'd0,  3'd3};
			5'd19:   c = '{4'd1,  3'd1};
			5'd20:   c = '{4'd4,  3'd3};
			5'd21:   c = '{4'd8,  3'd4};
			5'd22:   c = '{4'd6,  3'd3};
			5'd23:   c = '{4'd9,  3'd4};
			5'd24:   c = '{4'd13, 3'd4};
			5'd25:   c = '{4'd3,  3'd4};
			default: c = '{4'd0,  3'd0};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mlk_req_if.sv -----
// Request channel of the Morse letter keyer: valid/ready plus one request beat.
// Depends on mlk_pkg for the field widths.
`default_nettype none

interface mlk_req_if;
	import mlk_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [LetterW-1:0] letter;

	modport source (output valid, output req_type, output letter, input ready);
	modport sink (input valid, input req_type, input letter, output ready);
endinterface

`default_nettype wire

// ----- rtl/mlk_res_if.sv -----
// Result channel of the Morse letter keyer: valid/ready plus one result beat.
// Depends on mlk_pkg for the field widths.
`default_nettype none

interface mlk_res_if;
	import mlk_pkg::*;

	logic               valid;
	logic               ready;
	logic               led_on;
	logic               busy_res;
	logic [StatusW-1:0] load_status;

	modport source (output valid, output led_on, output busy_res, output load_status,
		input ready);
	modport sink (input valid, input led_on, input busy_res, input load_status,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/mlk_cfg_if.sv -----
// Configuration write channel of the Morse letter keyer: valid/ready plus unit length.
// Depends on mlk_pkg for the data width.
`default_nettype none

interface mlk_cfg_if;
	import mlk_pkg::*;

	logic             valid;
	logic             ready;
	logic [UnitW-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/morse_letter_led_keyer_unit.sv -----
// Top level of the Morse letter keyer: request register, sequencer and result register.
// Depends on mlk_pkg and the interfaces mlk_req_if, mlk_res_if and mlk_cfg_if.
//
// Each request beat either loads a letter (a to z as 0 to 25) or stands for one tick.
// A loaded letter is keyed on the LED: a dot is on for one unit and a dash for three,
// every mark is followed by one unit off and the letter closes with two more units off.
// One unit is unit_ticks ticks, which the user writes through the configuration channel
// only while the block is idle (the block does not enforce it); cfg is always ready.
// Every request beat gives exactly one result beat with the LED level, the busy flag
// and the load status (tick, accepted, rejected busy, rejected invalid letter).
// A request is registered in the cycle it is accepted and its result is registered
// from it in the result register, which can wait on a stalled receiver. One request
// can be taken in every cycle for as long as results are taken.
// When the receiver stalls, the waiting result holds and one more request can still
// be registered behind it; then the request channel drops ready.
// Reset leaves the block idle with the LED off, both stages empty and unit_ticks at
// 300000.
`default_nettype none

module morse_letter_led_keyer_unit (
	input wire logic clk,
	input wire logic arst_n,
	mlk_req_if.sink  req,
	mlk_res_if.source res,
	mlk_cfg_if.sink  cfg
);
	import mlk_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_MARK = 2'd1,
		PH_GAP  = 2'd2,
		PH_END  = 2'd3
	} phase_t;

	logic [UnitW-1:0]   unit_ticks_q;
	logic               valid_s1;
	logic               req_type_s1;
	logic [LetterW-1:0] letter_s1;

	phase_t             phase_q, phase_d;
	logic [PatW-1:0]    pattern_q, pattern_d;
	logic [CountW-1:0]  count_q, count_d;
	logic [IndexW-1:0]  index_q, index_d;
	logic [UnitsW-1:0]  units_q, units_d;
	logic [UnitW-1:0]   tick_q, tick_d;
	load_status_t       status_d;

	logic               out_valid_q;
	logic               led_q;
	logic               busy_q;
	load_status_t       status_q;

	logic               advance;
	morse_code_t        code;
	logic [UnitsW-1:0]  units_dec;
	logic [IndexW-1:0]  index_inc;

	assign advance   = !out_valid_q || res.ready;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign res.valid       = out_valid_q;
	assign res.led_on      = led_q;
	assign res.busy_res    = busy_q;
	assign res.load_status = status_q;

	assign code      = morse_lookup(letter_s1);
	assign units_dec = units_q - UnitsW'(1);
	assign index_inc = index_q + IndexW'(1);

	always_comb begin
		phase_d   = phase_q;
		pattern_d = pattern_q;
		count_d   = count_q;
		index_d   = index_q;
		units_d   = units_q;
		tick_d    = tick_q;
		status_d  = ST_TICK;
		if (req_type_s1 == REQ_LOAD) begin
			if (phase_q != PH_IDLE) begin
				status_d = ST_BUSY;
			end else if (letter_s1 >= LETTER_COUNT) begin
				status_d = ST_INVALID;
			end else begin
				status_d  = ST_LOADED;
				pattern_d = code.pattern;
				count_d   = code.count;
				index_d   = '0;
				tick_d    = '0;
				phase_d   = PH_MARK;
				units_d   = code.pattern[0] ? UnitsW'(3) : UnitsW'(1);
			end
		end else if (phase_q != PH_IDLE) begin
			if ({1'b0, tick_q} + (UnitW + 1)'(1) >= {1'b0, unit_ticks_q}) begin
				tick_d  = '0;
				units_d = units_dec;
				if (units_dec == '0) begin
					case (phase_q)
						PH_MARK: begin
							phase_d = PH_GAP;
							units_d = UnitsW'(1);
						end
						PH_GAP: begin
							if ({1'b0, index_q} + CountW'(1) < count_q) begin
								index_d = index_inc;
								phase_d = PH_MARK;
								units_d = pattern_q[index_inc] ? UnitsW'(3) : UnitsW'(1);
							end else begin
								phase_d = PH_END;
								units_d = UnitsW'(2);
							end
						end
						PH_END: begin
							phase_d = PH_IDLE;
							index_d = '0;
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
				end
			end else begin
				tick_d = tick_q + UnitW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RST;
			valid_s1     <= 1'b0;
			phase_q      <= PH_IDLE;
			pattern_q    <= '0;
			count_q      <= '0;
			index_q      <= '0;
			units_q      <= '0;
			tick_q       <= '0;
			out_valid_q  <= 1'b0;
			led_q        <= 1'b0;
			busy_q       <= 1'b0;
			status_q     <= ST_TICK;
		end else begin
			if (cfg.valid) begin
				unit_ticks_q <= cfg.data;
			end
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					phase_q   <= phase_d;
					pattern_q <= pattern_d;
					count_q   <= count_d;
					index_q   <= index_d;
					units_q   <= units_d;
					tick_q    <= tick_d;
					led_q     <= (phase_d == PH_MARK);
					busy_q    <= (phase_d != PH_IDLE);
					status_q  <= status_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			letter_s1   <= req.letter;
		end
	end

endmodule

`default_nettype wire

// ----- dv/tb_morse_letter_led_keyer_unit.sv -----
// Self-checking testbench for morse_letter_led_keyer_unit: directed and random request beats,
// predicted results compared beat by beat. Depends on mlk_pkg and the interfaces
// mlk_req_if, mlk_res_if and mlk_cfg_if.
`timescale 1ns / 1ps

module tb_morse_letter_led_keyer_unit;
	import mlk_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam logic [UnitW-1:0] UNIT_MAX = {UnitW{1'b1}};

	// Dash bits and mark counts per letter, listed from z down to a.
	localparam logic [25:0][PatW-1:0] DASH_BITS = {
		4'd3, 4'd13, 4'd9, 4'd6, 4'd8, 4'd4, 4'd1, 4'd0, 4'd2, 4'd11, 4'd6, 4'd7, 4'd1,
		4'd3, 4'd2, 4'd5, 4'd14, 4'd0, 4'd0, 4'd3, 4'd4, 4'd0, 4'd1, 4'd5, 4'd1, 4'd2
	};
	localparam logic [25:0][CountW-1:0] MARK_COUNT = {
		3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd1, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd2,
		3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd1, 3'd3, 3'd4, 3'd4, 3'd2
	};

	typedef enum logic [1:0] {
		KEY_IDLE  = 2'd0,
		KEY_MARK  = 2'd1,
		KEY_GAP   = 2'd2,
		KEY_CLOSE = 2'd3
	} key_phase_t;

	typedef struct packed {
		logic         led_on;
		logic         busy;
		load_status_t status;
	} keyer_result_t;

	logic clk;
	logic arst_n;

	mlk_req_if req_bus();
	mlk_res_if res_bus();
	mlk_cfg_if cfg_bus();

	morse_letter_led_keyer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.res(res_bus),
		.cfg(cfg_bus)
	);

	keyer_result_t expected_beats[$];
	int fault_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	logic [UnitW-1:0]  unit_ticks = UNIT_TICKS_RST;
	logic [PatW-1:0]   pattern = '0;
	logic [CountW-1:0] mark_total = '0;
	logic [IndexW-1:0] mark_index = '0;
	key_phase_t        phase = KEY_IDLE;
	logic [UnitsW-1:0] units_left = '0;
	logic [UnitW-1:0]  tick_count = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic keyer_result_t key_step(input req_type_t kind,
		input logic [LetterW-1:0] code);
		keyer_result_t r;
		logic [UnitW:0] next_tick;
		r.status = ST_TICK;
		next_tick = {1'b0, tick_count} + 1'b1;
		if (kind == REQ_LOAD) begin
			if (phase != KEY_IDLE) begin
				r.status = ST_BUSY;
			end else if (code >= LETTER_COUNT) begin
				r.status = ST_INVALID;
			end else begin
				r.status = ST_LOADED;
				pattern = DASH_BITS[code];
				mark_total = MARK_COUNT[code];
				mark_index = '0;
				tick_count = '0;
				phase = KEY_MARK;
				units_left = pattern[0] ? 2'd3 : 2'd1;
			end
		end else if (phase != KEY_IDLE) begin
			if (next_tick >= {1'b0, unit_ticks}) begin
				tick_count = '0;
				units_left = units_left - 1'b1;
				if (units_left == 0) begin
					case (phase)
						KEY_MARK: begin
							phase = KEY_GAP;
							units_left = 2'd1;
						end
						KEY_GAP: begin
							if ({1'b0, mark_index} + 3'd1 < mark_total) begin
								mark_index = mark_index + 1'b1;
								phase = KEY_MARK;
								units_left = pattern[mark_index] ? 2'd3 : 2'd1;
							end else begin
								phase = KEY_CLOSE;
								units_left = 2'd2;
							end
						end
						default: begin
							phase = KEY_IDLE;
							mark_index = '0;
						end
					endcase
				end
			end else begin
				tick_count = next_tick[UnitW-1:0];
			end
		end
		r.led_on = (phase == KEY_MARK);
		r.busy = (phase != KEY_IDLE);
		return r;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic send_beat(input req_type_t kind, input logic [LetterW-1:0] code);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		req_bus.valid = 1'b1;
		req_bus.req_type = kind;
		req_bus.letter = code;
		do @(posedge clk); while (!req_bus.ready);
		expected_beats.push_back(key_step(kind, code));
		@(negedge clk);
		req_bus.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_unit(input logic [UnitW-1:0] value);
		wait_drained();
		cfg_bus.valid = 1'b1;
		cfg_bus.data = value;
		do @(posedge clk); while (!cfg_bus.ready);
		unit_ticks = value;
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic finish_letter();
		while (phase != KEY_IDLE)
			send_beat(REQ_TICK, 5'($urandom_range(31)));
	endtask

	// At the reset unit length only beats that leave the keyer idle are sent.
	task automatic test_reset_state();
		send_beat(REQ_TICK, 5'd0);
		send_beat(REQ_TICK, 5'd31);
		send_beat(REQ_LOAD, 5'd26);
		send_beat(REQ_LOAD, 5'd31);
		send_beat(REQ_TICK, 5'd21);
	endtask

	task automatic test_unit_zero();
		write_unit('0);
		send_beat(REQ_LOAD, 5'd19);
		send_beat(REQ_LOAD, 5'd31);
		send_beat(REQ_LOAD, 5'd4);
		finish_letter();
		send_beat(REQ_TICK, 5'd10);
	endtask

	task automatic test_shortest_unit();
		write_unit(24'd1);
		send_beat(REQ_LOAD, 5'd25);
		send_beat(REQ_LOAD, 5'd0);
		finish_letter();
		send_beat(REQ_LOAD, 5'd4);
		finish_letter();
	endtask

	task automatic test_random_letters(input int beats);
		int sent;
		int steps;
		sent = 0;
		while (sent < beats) begin
			if ($urandom_range(99) < 75) begin
				send_beat(REQ_LOAD, 5'($urandom_range(25)));
				sent++;
				while (phase != KEY_IDLE) begin
					if ($urandom_range(99) < 8)
						send_beat(REQ_LOAD, 5'($urandom_range(31)));
					else
						send_beat(REQ_TICK, 5'($urandom_range(31)));
					sent++;
				end
			end else begin
				case ($urandom_range(2))
					0: send_beat(REQ_TICK, 5'($urandom_range(31)));
					1: send_beat(REQ_LOAD, 5'($urandom_range(26, 31)));
					default: begin
						send_beat(REQ_LOAD, 5'($urandom_range(31)));
						steps = $urandom_range(0, 5);
						repeat (steps) send_beat(REQ_TICK, 5'($urandom_range(31)));
						sent += steps;
					end
				endcase
				sent++;
			end
		end
		finish_letter();
	endtask

	// The receiver holds off while beats keep coming, so the request channel stalls.
	task automatic test_backpressure();
		int saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		hold_left = 80;
		send_beat(REQ_LOAD, 5'($urandom_range(25)));
		repeat (12) send_beat(REQ_TICK, 5'($urandom_range(31)));
		finish_letter();
		send_idle_pct = saved_pct;
		wait_drained();
	endtask

	// The keyer is left mid-letter here, so this must stay the last test.
	task automatic test_longest_unit();
		write_unit(UNIT_MAX);
		send_beat(REQ_LOAD, 5'd16);
		repeat (15) send_beat(REQ_TICK, 5'($urandom_range(31)));
		send_beat(REQ_LOAD, 5'd31);
		send_beat(REQ_LOAD, 5'd2);
		repeat (5) send_beat(REQ_TICK, 5'($urandom_range(31)));
	endtask

	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready = 1'b0;
			end else begin
				res_bus.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		keyer_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_beats.size() == 0) begin
				note_fault($sformatf("result beat with none expected: led %0b busy %0b status %0d",
					res_bus.led_on, res_bus.busy_res, res_bus.load_status));
			end else begin
				want = expected_beats.pop_front();
				if (res_bus.led_on !== want.led_on || res_bus.busy_res !== want.busy ||
					res_bus.load_status !== want.status)
					note_fault($sformatf(
						"mismatch: expected led %0b busy %0b status %0d, got led %0b busy %0b status %0d",
						want.led_on, want.busy, want.status,
						res_bus.led_on, res_bus.busy_res, res_bus.load_status));
			end
		end
	end

	initial begin : watchdog
		int idle_run;
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("morse_letter_led_keyer_unit verification failed");
		$finish;
	end

	initial begin
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_TICK;
		req_bus.letter = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_unit_zero();
		test_shortest_unit();

		send_idle_pct = 20;
		recv_idle_pct = 62;
		write_unit(24'd2);
		test_random_letters(130);

		send_idle_pct = 62;
		recv_idle_pct = 20;
		write_unit(24'($urandom_range(3, 5)));
		test_random_letters(130);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_unit(24'd1);
		test_random_letters(110);
		test_backpressure();
		test_longest_unit();

		wait_drained();
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("morse_letter_led_keyer_unit verification clean");
		else
			$display("morse_letter_led_keyer_unit verification failed");
		$finish;
	end

endmodule
